FILE: rtl/rgbhsl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbhsl_pkg
// Types and constants shared by the RGB to HSL converter files.
// ----------------------------------------------------------------------------
package rgbhsl_pkg;

  localparam int CH_W    = 8;   // one color channel
  localparam int HUE_W   = 13;  // hue in sixteenths of a degree
  localparam int HQ_W    = 10;  // hue quotient, at most 960
  localparam int HACC_W  = CH_W + HQ_W;
  localparam int SQ_W    = 8;   // saturation quotient, at most 255
  localparam int SACC_W  = CH_W + SQ_W;
  localparam int DIV_STEPS = HQ_W;

  localparam logic signed [HUE_W:0] HUE_GREEN = 14'sd1920;
  localparam logic signed [HUE_W:0] HUE_BLUE  = 14'sd3840;
  localparam logic signed [HUE_W:0] HUE_FULL  = 14'sd5760;

  // Which channel is the largest; ties go to red, then green.
  typedef enum logic [1:0] {
    SEL_RED,
    SEL_GREEN,
    SEL_BLUE
  } sel_t;

  // Payload of one item while it walks through the divider stages.
  typedef struct packed {
    logic              grey;
    sel_t              sel;
    logic              neg;
    logic [CH_W-1:0]   light;
    logic [CH_W-1:0]   d;
    logic [CH_W-1:0]   den;
    logic [HACC_W-1:0] hacc;
    logic [SACC_W-1:0] sacc;
  } div_t;

endpackage

FILE: rtl/rgbhsl_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbhsl_if
// Valid/ready channels for RGB pixels in and HSL results out.
// ----------------------------------------------------------------------------
interface rgbhsl_pix_if import rgbhsl_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] red;
  logic [CH_W-1:0] green;
  logic [CH_W-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface rgbhsl_hsl_if import rgbhsl_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [HUE_W-1:0] hue;
  logic [CH_W-1:0]  saturation;
  logic [CH_W-1:0]  lightness;

  modport source (output valid, output hue, output saturation, output lightness,
                  input ready);
  modport sink   (input valid, input hue, input saturation, input lightness,
                  output ready);
endinterface

FILE: rtl/rgbhsl_div_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbhsl_div_step
// One registered step of the two restoring dividers: one hue quotient bit
// and, where enabled, one saturation quotient bit.
// ----------------------------------------------------------------------------
module rgbhsl_div_step import rgbhsl_pkg::*; (
  input  logic clk,
  input  logic load,
  input  logic sat_step,
  input  div_t din,
  output div_t dout
);

  logic [CH_W:0]   htry;
  logic [CH_W:0]   hsub;
  logic            hge;
  logic [CH_W-1:0] hrem;
  logic [CH_W:0]   stry;
  logic [CH_W:0]   ssub;
  logic            sge;
  logic [CH_W-1:0] srem;
  div_t            dnext;

  // The accumulator holds the partial remainder above the bits still to be
  // shifted in; quotient bits enter at the bottom.
  always_comb begin
    htry = {din.hacc[HACC_W-1 -: CH_W], din.hacc[HQ_W-1]};
    hsub = htry - {1'b0, din.d};
    hge  = (htry >= {1'b0, din.d});
    hrem = hge ? hsub[CH_W-1:0] : htry[CH_W-1:0];

    stry = {din.sacc[SACC_W-1 -: CH_W], din.sacc[SQ_W-1]};
    ssub = stry - {1'b0, din.den};
    sge  = (stry >= {1'b0, din.den});
    srem = sge ? ssub[CH_W-1:0] : stry[CH_W-1:0];

    dnext = din;
    dnext.hacc = {hrem, din.hacc[HQ_W-2:0], hge};
    if (sat_step) begin
      dnext.sacc = {srem, din.sacc[SQ_W-2:0], sge};
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      dout <= dnext;
    end
  end

endmodule

FILE: rtl/rgb_to_hsl_converter.sv
`timescale 1ns / 1ps
// An accepted pixel passes stage A, stage B, the divider steps and the output register.
// Throughput: one pixel per cycle while the output does not stall; the ten-step hue divider sets the depth.
// Every stage has its own valid bit and fills bubbles while the output stalls.
// Reset (rst, synchronous) clears all valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
// rgb_to_hsl_converter
// Pipelined conversion of 8-bit RGB pixels into hue, saturation, lightness.
// ----------------------------------------------------------------------------
module rgb_to_hsl_converter import rgbhsl_pkg::*; (
  input  logic clk,
  input  logic rst,
  rgbhsl_pix_if.sink   pixel,
  rgbhsl_hsl_if.source color
);

  localparam int NSTG = DIV_STEPS + 3;

  logic [NSTG-1:0] vld;
  logic [NSTG:0]   rdy;

  // Stage A: largest and smallest channel and the hue difference.
  logic [CH_W-1:0]       a_mx;
  logic [CH_W-1:0]       a_mn;
  sel_t                  a_sel;
  logic signed [CH_W:0]  a_diff;
  logic [CH_W-1:0]       mx_c;
  logic [CH_W-1:0]       mn_c;
  sel_t                  sel_c;
  logic signed [CH_W:0]  diff_c;

  // Stage B: divider operands.
  div_t                  b_reg;
  logic [CH_W:0]         sum_c;
  logic [CH_W-1:0]       d_c;
  logic [CH_W:0]         far_c;
  logic [CH_W:0]         mag9_c;
  logic [HACC_W-1:0]     mag_w;
  logic [SACC_W-1:0]     d_w;
  div_t                  b_next;

  div_t                  stg [DIV_STEPS];

  // Output stage.
  logic [HUE_W-1:0]      hue_r;
  logic [CH_W-1:0]       sat_r;
  logic [CH_W-1:0]       light_r;
  logic signed [HUE_W:0] base_c;
  logic signed [HUE_W:0] q_c;
  logic signed [HUE_W:0] hs_c;
  logic signed [HUE_W:0] hw_c;
  div_t                  last;

  // Each stage takes a new item when it is empty or its item moves on.
  always_comb begin
    rdy[NSTG] = color.ready;
    for (int k = NSTG - 1; k >= 0; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  assign pixel.ready = rdy[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) begin
        vld[0] <= pixel.valid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (rdy[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  always_comb begin
    mx_c = pixel.red;
    if (pixel.green > mx_c) mx_c = pixel.green;
    if (pixel.blue > mx_c) mx_c = pixel.blue;
    mn_c = pixel.red;
    if (pixel.green < mn_c) mn_c = pixel.green;
    if (pixel.blue < mn_c) mn_c = pixel.blue;

    if (mx_c == pixel.red) begin
      sel_c  = SEL_RED;
      diff_c = $signed({1'b0, pixel.green}) - $signed({1'b0, pixel.blue});
    end else if (mx_c == pixel.green) begin
      sel_c  = SEL_GREEN;
      diff_c = $signed({1'b0, pixel.blue}) - $signed({1'b0, pixel.red});
    end else begin
      sel_c  = SEL_BLUE;
      diff_c = $signed({1'b0, pixel.red}) - $signed({1'b0, pixel.green});
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      a_mx   <= mx_c;
      a_mn   <= mn_c;
      a_sel  <= sel_c;
      a_diff <= diff_c;
    end
  end

  always_comb begin
    sum_c  = {1'b0, a_mx} + {1'b0, a_mn};
    d_c    = a_mx - a_mn;
    far_c  = 9'd510 - sum_c;
    mag9_c = a_diff[CH_W] ? (-a_diff) : a_diff;
    mag_w  = {{(HACC_W-CH_W){1'b0}}, mag9_c[CH_W-1:0]};
    d_w    = {{(SACC_W-CH_W){1'b0}}, d_c};

    b_next.grey  = (d_c == '0);
    b_next.sel   = a_sel;
    b_next.neg   = a_diff[CH_W];
    b_next.light = sum_c[CH_W:1];
    b_next.d     = d_c;
    b_next.den   = (sum_c < 9'd255) ? sum_c[CH_W-1:0] : far_c[CH_W-1:0];
    // 960 * |diff| and 255 * d as shifts and a subtract.
    b_next.hacc  = (mag_w << 10) - (mag_w << 6);
    b_next.sacc  = (d_w << 8) - d_w;
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      b_reg <= b_next;
    end
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    rgbhsl_div_step u_step (
      .clk      (clk),
      .load     (rdy[k+2]),
      .sat_step (k < SQ_W),
      .din      ((k == 0) ? b_reg : stg[(k == 0) ? 0 : k-1]),
      .dout     (stg[k])
    );
  end

  assign last = stg[DIV_STEPS-1];

  always_comb begin
    case (last.sel)
      SEL_GREEN: base_c = HUE_GREEN;
      SEL_BLUE:  base_c = HUE_BLUE;
      default:   base_c = '0;
    endcase
    q_c  = $signed({{(HUE_W+1-HQ_W){1'b0}}, last.hacc[HQ_W-1:0]});
    hs_c = last.neg ? (base_c - q_c) : (base_c + q_c);
    hw_c = hs_c[HUE_W] ? (hs_c + HUE_FULL) : hs_c;
  end

  always_ff @(posedge clk) begin
    if (rdy[NSTG-1]) begin
      hue_r   <= last.grey ? '0 : hw_c[HUE_W-1:0];
      sat_r   <= last.grey ? '0 : last.sacc[SQ_W-1:0];
      light_r <= last.light;
    end
  end

  assign color.valid      = vld[NSTG-1];
  assign color.hue        = hue_r;
  assign color.saturation = sat_r;
  assign color.lightness  = light_r;

endmodule

FILE: test/rgb_to_hsl_converter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_to_hsl_converter_tb
// Drives RGB pixels through the converter with random gaps on the input and
// random stalls on the output. Every result is checked against the expected
// hue, saturation and lightness, queued for each accepted pixel. A short
// list of known colors comes first, then biased random pixels.
// ----------------------------------------------------------------------------
module rgb_to_hsl_converter_tb;
  import rgbhsl_pkg::*;

  typedef struct {
    logic [CH_W-1:0]  red;
    logic [CH_W-1:0]  green;
    logic [CH_W-1:0]  blue;
    logic [HUE_W-1:0] hue;
    logic [CH_W-1:0]  saturation;
    logic [CH_W-1:0]  lightness;
  } hsl_result_t;

  typedef struct {
    logic [CH_W-1:0]  red;
    logic [CH_W-1:0]  green;
    logic [CH_W-1:0]  blue;
    bit               known;
    logic [HUE_W-1:0] hue;
    logic [CH_W-1:0]  saturation;
    logic [CH_W-1:0]  lightness;
  } color_case_t;

  localparam int RANDOM_PIXELS = 1400;
  localparam int DRAIN_CYCLES  = 30;

  logic clk = 1'b0;
  logic rst = 1'b1;

  rgbhsl_pix_if pix ();
  rgbhsl_hsl_if hsl ();

  rgb_to_hsl_converter uut (
    .clk   (clk),
    .rst   (rst),
    .pixel (pix.sink),
    .color (hsl.source)
  );

  always #4 clk = ~clk;

  hsl_result_t pending_hsl[$];
  int          failures = 0;
  bit          pix_burst = 1'b0;
  bit          hsl_burst = 1'b0;

  // Known colors carry their result; the rest are left to the predictor.
  color_case_t known_colors[] = '{
    '{8'd0,   8'd0,   8'd0,   1'b1, 13'd0,    8'd0,   8'd0},
    '{8'd255, 8'd255, 8'd255, 1'b1, 13'd0,    8'd0,   8'd255},
    '{8'd128, 8'd128, 8'd128, 1'b1, 13'd0,    8'd0,   8'd128},
    '{8'd255, 8'd0,   8'd0,   1'b1, 13'd0,    8'd255, 8'd127},
    '{8'd0,   8'd255, 8'd0,   1'b1, 13'd1920, 8'd255, 8'd127},
    '{8'd0,   8'd0,   8'd255, 1'b1, 13'd3840, 8'd255, 8'd127},
    '{8'd255, 8'd255, 8'd0,   1'b1, 13'd960,  8'd255, 8'd127},
    '{8'd0,   8'd255, 8'd255, 1'b1, 13'd2880, 8'd255, 8'd127},
    '{8'd255, 8'd0,   8'd255, 1'b1, 13'd4800, 8'd255, 8'd127},
    '{8'd255, 8'd0,   8'd1,   1'b0, 13'd0,    8'd0,   8'd0},
    '{8'd1,   8'd0,   8'd0,   1'b0, 13'd0,    8'd0,   8'd0},
    '{8'd0,   8'd1,   8'd0,   1'b0, 13'd0,    8'd0,   8'd0},
    '{8'd0,   8'd0,   8'd1,   1'b0, 13'd0,    8'd0,   8'd0},
    '{8'd127, 8'd127, 8'd0,   1'b0, 13'd0,    8'd0,   8'd0},
    '{8'd254, 8'd0,   8'd0,   1'b0, 13'd0,    8'd0,   8'd0},
    '{8'd200, 8'd55,  8'd55,  1'b0, 13'd0,    8'd0,   8'd0},
    '{8'd200, 8'd54,  8'd54,  1'b0, 13'd0,    8'd0,   8'd0},
    '{8'd255, 8'd254, 8'd254, 1'b0, 13'd0,    8'd0,   8'd0},
    '{8'd128, 8'd127, 8'd127, 1'b0, 13'd0,    8'd0,   8'd0},
    '{8'd10,  8'd200, 8'd200, 1'b0, 13'd0,    8'd0,   8'd0},
    '{8'd100, 8'd50,  8'd75,  1'b0, 13'd0,    8'd0,   8'd0},
    '{8'd50,  8'd100, 8'd75,  1'b0, 13'd0,    8'd0,   8'd0},
    '{8'd75,  8'd50,  8'd100, 1'b0, 13'd0,    8'd0,   8'd0},
    '{8'd1,   8'd2,   8'd3,   1'b0, 13'd0,    8'd0,   8'd0},
    '{8'd254, 8'd255, 8'd253, 1'b0, 13'd0,    8'd0,   8'd0}
  };

  function automatic hsl_result_t rgb_to_hsl(input logic [CH_W-1:0] r,
                                             input logic [CH_W-1:0] g,
                                             input logic [CH_W-1:0] b);
    hsl_result_t res;
    sel_t        sel;
    int          hi;
    int          lo;
    int          sum;
    int          d;
    int          hue;
    int          sat;
    hi  = r;
    sel = SEL_RED;
    if (int'(g) > hi) begin
      hi  = g;
      sel = SEL_GREEN;
    end
    if (int'(b) > hi) begin
      hi  = b;
      sel = SEL_BLUE;
    end
    lo = r;
    if (int'(g) < lo) lo = g;
    if (int'(b) < lo) lo = b;
    sum = hi + lo;
    d   = hi - lo;
    hue = 0;
    sat = 0;
    if (d != 0) begin
      sat = (sum < 255) ? (255 * d) / sum : (255 * d) / (510 - sum);
      // Integer division on int truncates toward zero.
      case (sel)
        SEL_RED:   hue = (960 * (int'(g) - int'(b))) / d;
        SEL_GREEN: hue = HUE_GREEN + (960 * (int'(b) - int'(r))) / d;
        default:   hue = HUE_BLUE + (960 * (int'(r) - int'(g))) / d;
      endcase
      if (hue < 0) hue += HUE_FULL;
    end
    res.red        = r;
    res.green      = g;
    res.blue       = b;
    res.hue        = hue[HUE_W-1:0];
    res.saturation = sat[CH_W-1:0];
    res.lightness  = sum[CH_W:1];
    return res;
  endfunction

  task automatic report_failure(input string msg);
    $display("%0t ns: %s", $time, msg);
    failures++;
  endtask

  // Waits a random gap, then holds the pixel until the converter takes it.
  task automatic send_pixel(input hsl_result_t want);
    int gap;
    gap = pix_burst ? 0 : $urandom_range(0, 5);
    repeat (gap) begin
      @(negedge clk);
      pix.valid <= 1'b0;
    end
    @(negedge clk);
    pix.valid <= 1'b1;
    pix.red   <= want.red;
    pix.green <= want.green;
    pix.blue  <= want.blue;
    do @(posedge clk); while (pix.ready !== 1'b1);
    pending_hsl.push_back(want);
  endtask

  function automatic int clamp_channel(input int v);
    return (v < 0) ? 0 : (v > 255) ? 255 : v;
  endfunction

  // Random pixels lean toward greys, ties, extremes, near-greys and the
  // point where max + min crosses 255, where the saturation divisor changes.
  task automatic random_pixel(output hsl_result_t want);
    int v[3];
    int t;
    int rot;
    case ($urandom_range(0, 9))
      0: begin
        v[0] = $urandom_range(0, 255);
        v[1] = v[0];
        v[2] = v[0];
      end
      1: begin
        v[0] = $urandom_range(0, 255);
        v[1] = v[0];
        v[2] = $urandom_range(0, 255);
      end
      2: begin
        for (int i = 0; i < 3; i++) begin
          t    = $urandom_range(0, 3);
          v[i] = (t == 0) ? 0 : (t == 1) ? 1 : (t == 2) ? 254 : 255;
        end
      end
      3: begin
        t = $urandom_range(0, 255);
        for (int i = 0; i < 3; i++) v[i] = clamp_channel(t + $urandom_range(0, 4) - 2);
      end
      4: begin
        v[0] = $urandom_range(0, 255);
        v[1] = clamp_channel(255 - v[0] + $urandom_range(0, 2) - 1);
        t    = (v[0] < v[1]) ? v[0] : v[1];
        v[2] = $urandom_range(t, (v[0] < v[1]) ? v[1] : v[0]);
      end
      default: begin
        for (int i = 0; i < 3; i++) v[i] = $urandom_range(0, 255);
      end
    endcase
    if ($urandom_range(0, 1)) begin
      t    = v[0];
      v[0] = v[1];
      v[1] = t;
    end
    rot  = $urandom_range(0, 2);
    want = rgb_to_hsl(CH_W'(v[rot]), CH_W'(v[(rot + 1) % 3]), CH_W'(v[(rot + 2) % 3]));
  endtask

  initial begin
    hsl_result_t want;
    pix.valid = 1'b0;
    pix.red   = '0;
    pix.green = '0;
    pix.blue  = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (known_colors[i]) begin
      want = rgb_to_hsl(known_colors[i].red, known_colors[i].green, known_colors[i].blue);
      if (known_colors[i].known) begin
        want.hue        = known_colors[i].hue;
        want.saturation = known_colors[i].saturation;
        want.lightness  = known_colors[i].lightness;
      end
      send_pixel(want);
    end

    for (int n = 0; n < RANDOM_PIXELS; n++) begin
      if (n % 64 == 0) pix_burst = ($urandom_range(0, 2) == 0);
      random_pixel(want);
      send_pixel(want);
    end
    @(negedge clk);
    pix.valid <= 1'b0;

    while (pending_hsl.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Output side: random stalls on ready, each accepted item checked in order.
  initial begin
    hsl_result_t want;
    int          stall;
    int          taken;
    hsl.ready = 1'b0;
    taken     = 0;
    while (rst) @(negedge clk);
    forever begin
      stall = hsl_burst ? 0 : $urandom_range(0, 5);
      repeat (stall) begin
        @(negedge clk);
        hsl.ready <= 1'b0;
      end
      @(negedge clk);
      hsl.ready <= 1'b1;
      do @(posedge clk); while (hsl.valid !== 1'b1);
      if (pending_hsl.size() == 0) begin
        report_failure($sformatf("unexpected result hue %0d sat %0d light %0d",
                                 hsl.hue, hsl.saturation, hsl.lightness));
      end else begin
        want = pending_hsl.pop_front();
        if (hsl.hue !== want.hue)
          report_failure($sformatf("hue of rgb(%0d,%0d,%0d): got %0d, expected %0d",
                                   want.red, want.green, want.blue, hsl.hue, want.hue));
        if (hsl.saturation !== want.saturation)
          report_failure($sformatf("saturation of rgb(%0d,%0d,%0d): got %0d, expected %0d",
                                   want.red, want.green, want.blue, hsl.saturation,
                                   want.saturation));
        if (hsl.lightness !== want.lightness)
          report_failure($sformatf("lightness of rgb(%0d,%0d,%0d): got %0d, expected %0d",
                                   want.red, want.green, want.blue, hsl.lightness,
                                   want.lightness));
      end
      taken++;
      if (taken % 80 == 0) hsl_burst = ($urandom_range(0, 2) == 0);
    end
  end

  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

FILE: files.f
rtl/rgbhsl_pkg.sv
rtl/rgbhsl_if.sv
rtl/rgbhsl_div_step.sv
rtl/rgb_to_hsl_converter.sv
test/rgb_to_hsl_converter_tb.sv
